// ===== sv/agad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agad_pkg
// Shared widths, register codes, reset values and word types of the Adam
// gradient adjuster.
// ----------------------------------------------------------------------------
package agad_pkg;

	localparam int IDX_W   = 10;
	localparam int GRAD_W  = 32;
	localparam int M2_W    = 48;
	localparam int POW_W   = 32;
	localparam int BETA_W  = 16;
	localparam int EPS_W   = 32;

	localparam int NUM_PARAMS_DEF = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 2'd2;

	localparam logic [BETA_W-1:0] DECAY_FIRST_RST  = 16'd58982;
	localparam logic [BETA_W-1:0] DECAY_SECOND_RST = 16'd65470;
	localparam logic [EPS_W-1:0]  EPSILON_RST      = 32'd429497;

	// one in Q0.32, saturated
	localparam logic [POW_W-1:0] POW_ONE = 32'hFFFF_FFFF;

	// division and root pipeline depths and divisor widths
	localparam int DIV_K   = 62;
	localparam int DIV_DW  = 33;
	localparam int FIN_K   = 33;
	localparam int FIN_DW  = 32;
	localparam int ROOT_N  = 32;

	localparam logic [62:0] A_MAX = 63'h4000_0000_0000_0000;
	localparam logic [48:0] H_MAX = 49'h1_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [IDX_W-1:0]         param_index;
		logic signed [GRAD_W-1:0] grad_value;
		logic                     step_begin;
		logic                     run_begin;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [GRAD_W-1:0] adjusted_grad;
		logic                     saturated;
	} out_word_t;

	typedef struct packed {
		logic [BETA_W-1:0] decay_first;
		logic [BETA_W-1:0] decay_second;
		logic [EPS_W-1:0]  epsilon;
	} cfg_t;

	// moment stage result handed to the divider pipelines
	typedef struct packed {
		logic                     valid;
		logic [IDX_W-1:0]         idx;
		logic signed [GRAD_W-1:0] m1;
		logic [M2_W-1:0]          m2;
		logic [POW_W-1:0]         pf;
		logic [POW_W-1:0]         ps;
	} front_out_t;

endpackage

// ===== sv/agad_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agad_stream_if
// Valid/ready stream channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface agad_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/agad_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agad_front
// Decay powers, moment stores and the two-stage moment update with
// forwarding for back-to-back words on the same index.
// ----------------------------------------------------------------------------
module agad_front import agad_pkg::*; #(
	parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  in_word_t   in_word,
	input  cfg_t       cfg,
	output front_out_t res
);

	localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

	logic signed [GRAD_W-1:0] m1_mem [NUM_PARAMS];
	logic [M2_W-1:0]          m2_mem [NUM_PARAMS];

	logic [POW_W-1:0] pf_q, ps_q;
	logic [POW_W-1:0] pf_base, ps_base, pf_next, ps_next;
	logic [47:0]      pf_prod, ps_prod;
	logic             acc;

	logic [GRAD_W-1:0] gmag;
	logic [63:0]       gsq;
	logic [IDX_W+AW-1:0] idx_ext;
	logic [AW-1:0]     addr_in;
	logic              ok_in;

	// stage 1
	logic                     v_s1, ok_s1, run_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [AW-1:0]            addr_s1;
	logic signed [GRAD_W-1:0] g_s1;
	logic [46:0]              q_s1;
	logic [POW_W-1:0]         pf_s1, ps_s1;
	logic signed [GRAD_W-1:0] m1_rd_s1;
	logic [M2_W-1:0]          m2_rd_s1;

	// stage 2
	logic                     v_s2, ok_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [GRAD_W-1:0] m1_s2;
	logic [M2_W-1:0]          m2_s2;
	logic [POW_W-1:0]         pf_s2, ps_s2;

	logic                     fwd;
	logic signed [GRAD_W-1:0] m1o, m1n;
	logic [M2_W-1:0]          m2o, m2n;
	logic signed [16:0]       b1s;
	logic [16:0]              w1, w2;
	logic signed [17:0]       w1s;
	logic signed [48:0]       p1;
	logic signed [49:0]       p2;
	logic signed [50:0]       t1;
	logic [63:0]              p3, p4;
	logic [64:0]              t2;

	assign acc = en && in_valid;

	// powers advance at an accepted step_begin word; the word carries the updated pair
	assign pf_base = in_word.run_begin ? POW_ONE : pf_q;
	assign ps_base = in_word.run_begin ? POW_ONE : ps_q;
	assign pf_prod = 48'(pf_base) * 48'(cfg.decay_first) + 48'h8000;
	assign ps_prod = 48'(ps_base) * 48'(cfg.decay_second) + 48'h8000;
	assign pf_next = in_word.step_begin ? pf_prod[47:16] : pf_q;
	assign ps_next = in_word.step_begin ? ps_prod[47:16] : ps_q;

	assign gmag    = in_word.grad_value[GRAD_W-1] ?
	                 (~in_word.grad_value + 32'd1) : in_word.grad_value;
	assign gsq     = 64'(gmag) * 64'(gmag) + 64'h8000;
	assign idx_ext = (IDX_W+AW)'(in_word.param_index);
	assign addr_in = idx_ext[AW-1:0];
	assign ok_in   = 32'(in_word.param_index) < NUM_PARAMS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_q <= POW_ONE;
			ps_q <= POW_ONE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			if (acc) begin
				pf_q <= pf_next;
				ps_q <= ps_next;
			end
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1   <= ok_in;
			run_s1  <= in_word.run_begin;
			idx_s1  <= in_word.param_index;
			addr_s1 <= addr_in;
			g_s1    <= in_word.grad_value;
			q_s1    <= gsq[62:16];
			pf_s1   <= pf_next;
			ps_s1   <= ps_next;

			ok_s2   <= ok_s1;
			idx_s2  <= idx_s1;
			m1_s2   <= m1n;
			m2_s2   <= m2n;
			pf_s2   <= pf_s1;
			ps_s2   <= ps_s1;
		end
	end

	// store: read at accept, written as the word leaves stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			m1_rd_s1 <= m1_mem[addr_in];
			m2_rd_s1 <= m2_mem[addr_in];
			if (v_s1 && ok_s1) begin
				m1_mem[addr_s1] <= m1n;
				m2_mem[addr_s1] <= m2n;
			end
		end
	end

	// the word one ahead wrote on the same edge this one read
	assign fwd = v_s2 && ok_s2 && (idx_s2 == idx_s1);

	always_comb begin
		if (run_s1 || !ok_s1) begin
			m1o = '0;
			m2o = '0;
		end else if (fwd) begin
			m1o = m1_s2;
			m2o = m2_s2;
		end else begin
			m1o = m1_rd_s1;
			m2o = m2_rd_s1;
		end
	end

	assign b1s = $signed({1'b0, cfg.decay_first});
	assign w1  = 17'h1_0000 - {1'b0, cfg.decay_first};
	assign w1s = $signed({1'b0, w1});
	assign p1  = 49'(b1s) * 49'(m1o);
	assign p2  = 50'(w1s) * 50'(g_s1);
	assign t1  = 51'(p1) + 51'(p2) + 51'sd32768;
	assign m1n = t1[47:16];

	assign w2  = 17'h1_0000 - {1'b0, cfg.decay_second};
	assign p3  = 64'(cfg.decay_second) * 64'(m2o);
	assign p4  = 64'(w2) * 64'(q_s1);
	assign t2  = 65'(p3) + 65'(p4) + 65'h8000;
	assign m2n = t2[63:16];

	assign res.valid = v_s2;
	assign res.idx   = idx_s2;
	assign res.m1    = m1_s2;
	assign res.m2    = m2_s2;
	assign res.pf    = pf_s2;
	assign res.ps    = ps_s2;

endmodule

// ===== sv/agad_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agad_div
// Restoring divider, one quotient bit per pipeline stage. The caller
// guarantees the starting remainder is below the divisor.
// ----------------------------------------------------------------------------
module agad_div #(
	parameter int DW = 33,
	parameter int K  = 62,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] rem0,
	input  logic [K-1:0]  low,
	input  logic [DW-1:0] dvs,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [K-1:0]  quot,
	output logic [TW-1:0] out_tag
);

	logic          v_s   [K];
	logic [DW-1:0] rem_s [K];
	logic [K-1:0]  low_s [K];
	logic [K-1:0]  quo_s [K];
	logic [DW-1:0] dvs_s [K];
	logic [TW-1:0] tag_s [K];

	for (genvar k = 0; k < K; k++) begin : g_stage
		logic          v_p;
		logic [DW-1:0] rem_p;
		logic [K-1:0]  low_p;
		logic [K-1:0]  quo_p;
		logic [DW-1:0] dvs_p;
		logic [TW-1:0] tag_p;
		logic [DW:0]   trial, diff;
		logic          take;

		if (k == 0) begin : g_first
			assign v_p   = in_valid;
			assign rem_p = rem0;
			assign low_p = low;
			assign quo_p = '0;
			assign dvs_p = dvs;
			assign tag_p = tag;
		end else begin : g_next
			assign v_p   = v_s[k-1];
			assign rem_p = rem_s[k-1];
			assign low_p = low_s[k-1];
			assign quo_p = quo_s[k-1];
			assign dvs_p = dvs_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign trial = {rem_p, low_p[K-1]};
		assign take  = trial >= {1'b0, dvs_p};
		assign diff  = trial - {1'b0, dvs_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
				low_s[k] <= {low_p[K-2:0], 1'b0};
				quo_s[k] <= {quo_p[K-2:0], take};
				dvs_s[k] <= dvs_p;
				tag_s[k] <= tag_p;
			end
		end
	end

	assign out_valid = v_s[K-1];
	assign quot      = quo_s[K-1];
	assign out_tag   = tag_s[K-1];

endmodule

// ===== sv/agad_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agad_sqrt
// Integer square root of a 64-bit value, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module agad_sqrt import agad_pkg::*; #(
	parameter int TW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       radicand,
	input  logic [TW-1:0]     tag,
	output logic              out_valid,
	output logic [ROOT_N-1:0] root,
	output logic [TW-1:0]     out_tag
);

	logic              v_s    [ROOT_N];
	logic [33:0]       rem_s  [ROOT_N];
	logic [ROOT_N-1:0] root_s [ROOT_N];
	logic [63:0]       y_s    [ROOT_N];
	logic [TW-1:0]     tag_s  [ROOT_N];

	for (genvar k = 0; k < ROOT_N; k++) begin : g_stage
		logic              v_p;
		logic [33:0]       rem_p;
		logic [ROOT_N-1:0] root_p;
		logic [63:0]       y_p;
		logic [TW-1:0]     tag_p;
		logic [35:0]       cur, trial, diff;
		logic              take;

		if (k == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign y_p    = radicand;
			assign tag_p  = tag;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign y_p    = y_s[k-1];
			assign tag_p  = tag_s[k-1];
		end

		assign cur   = {rem_p, y_p[63:62]};
		assign trial = {2'b00, root_p, 2'b01};
		assign take  = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[33:0] : cur[33:0];
				root_s[k] <= {root_p[ROOT_N-2:0], take};
				y_s[k]    <= {y_p[61:0], 2'b00};
				tag_s[k]  <= tag_p;
			end
		end
	end

	assign out_valid = v_s[ROOT_N-1];
	assign root      = root_s[ROOT_N-1];
	assign out_tag   = tag_s[ROOT_N-1];

endmodule

// ===== sv/adam_gradient_adjuster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_gradient_adjuster
// Adam moment update and bias-corrected direction m1hat / sqrt(m2hat + eps).
// ----------------------------------------------------------------------------
// Takes one gradient word per cycle and returns one direction word per input
// word, in order, through the bit-serial pipelines: two moment stages, 62
// stages of bias-correction division, 32 stages of square root, one compare
// stage and 33 stages of final division, then a two-entry output buffer.
// Words on the same index may follow each other in consecutive cycles; the
// moment update forwards the previous word's result. Input stalls only when
// the output buffer is full and not drained. Moment stores hold garbage after
// reset: the first step of a run must carry run_begin. Write configuration
// only while the block is empty.
module adam_gradient_adjuster import agad_pkg::*; #(
	parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	agad_stream_if.sink           grad,
	agad_stream_if.source         adjusted,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg_q;
	front_out_t fo;
	logic       en;

	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	out_word_t  slot_q [2];
	logic       push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_first  <= DECAY_FIRST_RST;
			cfg_q.decay_second <= DECAY_SECOND_RST;
			cfg_q.epsilon      <= EPSILON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECAY_FIRST:  cfg_q.decay_first  <= cfg_data[BETA_W-1:0];
				REG_DECAY_SECOND: cfg_q.decay_second <= cfg_data[BETA_W-1:0];
				REG_EPSILON:      cfg_q.epsilon      <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign en         = (cnt_q != 2'd2) || adjusted.ready;
	assign grad.ready = en;

	agad_front #(.NUM_PARAMS(NUM_PARAMS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (grad.valid),
		.in_word  (grad.data),
		.cfg      (cfg_q),
		.res      (fo)
	);

	// bias correction setup
	logic        neg;
	logic [31:0] amag;
	logic [32:0] d1, d2;
	logic        ovf_a, ovf_h;

	assign neg   = fo.m1[GRAD_W-1];
	assign amag  = neg ? (~fo.m1 + 32'd1) : fo.m1;
	assign d1    = 33'h1_0000_0000 - {1'b0, fo.pf};
	assign d2    = 33'h1_0000_0000 - {1'b0, fo.ps};
	assign ovf_a = 33'(amag[31:30]) >= d1;
	assign ovf_h = 33'(fo.m2[47:17]) >= d2;

	logic             da_v, dh_v;
	logic [DIV_K-1:0] qa, qh;
	logic [11:0]      da_tag;
	logic             dh_ovf;

	agad_div #(.DW(DIV_DW), .K(DIV_K), .TW(12)) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fo.valid),
		.rem0      (33'(amag[31:30])),
		.low       ({amag[29:0], 32'd0}),
		.dvs       (d1),
		.tag       ({fo.idx, neg, ovf_a}),
		.out_valid (da_v),
		.quot      (qa),
		.out_tag   (da_tag)
	);

	// scaled by 2^13 so both dividers share one depth
	agad_div #(.DW(DIV_DW), .K(DIV_K), .TW(1)) u_div_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fo.valid),
		.rem0      (33'(fo.m2[47:17])),
		.low       ({fo.m2[16:0], 45'd0}),
		.dvs       (d2),
		.tag       (ovf_h),
		.out_valid (dh_v),
		.quot      (qh),
		.out_tag   (dh_ovf)
	);

	logic [62:0] aval;
	logic [48:0] hval;
	logic [49:0] hsum;

	assign aval = da_tag[0] ? A_MAX : {1'b0, qa};
	assign hval = dh_ovf ? H_MAX : qh[61:13];
	assign hsum = 50'(hval) + 50'(cfg_q.epsilon);

	logic              sq_v;
	logic [ROOT_N-1:0] sq_root;
	logic [73:0]       sq_tag;

	agad_sqrt #(.TW(74)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (da_v && dh_v),
		.radicand  ({hsum, 14'd0}),
		.tag       ({da_tag[11:2], da_tag[1], aval}),
		.out_valid (sq_v),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	// compare stage ahead of the final divider
	logic              v_sf, neg_sf, ovf_sf, azero_sf;
	logic [IDX_W-1:0]  idx_sf;
	logic [62:0]       a_sf;
	logic [ROOT_N-1:0] s_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_sf   <= sq_tag[73:64];
			neg_sf   <= sq_tag[63];
			a_sf     <= sq_tag[62:0];
			s_sf     <= sq_root;
			ovf_sf   <= sq_tag[62:10] >= 53'(sq_root);
			azero_sf <= sq_tag[62:0] == 63'd0;
		end
	end

	logic             fin_v;
	logic [FIN_K-1:0] qf;
	logic [12:0]      fin_tag;

	agad_div #(.DW(FIN_DW), .K(FIN_K), .TW(13)) u_div_f (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_sf),
		.rem0      (a_sf[41:10]),
		.low       ({a_sf[9:0], 23'd0}),
		.dvs       (s_sf),
		.tag       ({idx_sf, neg_sf, ovf_sf, azero_sf}),
		.out_valid (fin_v),
		.quot      (qf),
		.out_tag   (fin_tag)
	);

	logic        f_neg, f_ovf, f_azero;
	logic [32:0] lim;
	logic [31:0] mag;
	logic        sat;
	out_word_t   res_word;

	assign f_neg   = fin_tag[2];
	assign f_ovf   = fin_tag[1];
	assign f_azero = fin_tag[0];
	assign lim     = f_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;

	always_comb begin
		if (f_azero) begin
			mag = '0;
			sat = 1'b0;
		end else if (f_ovf || (qf > lim)) begin
			mag = lim[31:0];
			sat = 1'b1;
		end else begin
			mag = qf[31:0];
			sat = 1'b0;
		end
	end

	assign res_word.out_index     = fin_tag[12:3];
	assign res_word.adjusted_grad = f_neg ? (~mag + 32'd1) : mag;
	assign res_word.saturated     = sat;

	// two-entry output buffer
	assign push = en && fin_v;
	assign pop  = (cnt_q != 2'd0) && adjusted.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			wr_q <= wr_q ^ push;
			rd_q <= rd_q ^ pop;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= res_word;
		end
	end

	assign adjusted.valid = cnt_q != 2'd0;
	assign adjusted.data  = slot_q[rd_q];

endmodule

// ===== tb/sv/adam_direction_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_direction_checker
// Watches the gradient and direction channels and the register port. It
// computes the expected direction word for every accepted gradient word and
// compares each direction word, in order, against it.
// ----------------------------------------------------------------------------
module adam_direction_checker import agad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_word_t              in_word,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	logic [GRAD_W-1:0] m1_store [NUM_PARAMS_DEF];
	logic [M2_W-1:0]   m2_store [NUM_PARAMS_DEF];
	logic [POW_W-1:0]  beta1_pow, beta2_pow;
	logic [BETA_W-1:0] beta1, beta2;
	logic [EPS_W-1:0]  eps;
	out_word_t         direction_q[$];

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] pow_step(logic [31:0] p, logic [15:0] b);
		logic [63:0] prod;
		prod = {32'd0, p} * {48'd0, b} + 64'h8000;
		return prod[47:16];
	endfunction

	// updates moments and powers, returns the expected direction word
	function automatic out_word_t adam_direction(in_word_t w);
		out_word_t   o;
		longint      g, m1o, t, m1n;
		logic [63:0] m2o, gmag, q, m2n, d1, d2, amag, a, r, h, s, mag, lim;
		logic        neg, sat;
		m1o = 0;
		m2o = 0;
		sat = 0;
		if (w.step_begin) begin
			beta1_pow = pow_step(w.run_begin ? POW_ONE : beta1_pow, beta1);
			beta2_pow = pow_step(w.run_begin ? POW_ONE : beta2_pow, beta2);
		end
		if (!w.run_begin) begin
			m1o = longint'($signed(m1_store[w.param_index]));
			m2o = {16'd0, m2_store[w.param_index]};
		end
		g = longint'($signed(w.grad_value));
		t = longint'({48'd0, beta1}) * m1o + longint'(65536 - int'(beta1)) * g;
		m1n = (t + 64'sh8000) >>> 16;
		gmag = g < 0 ? -g : g;
		q = (gmag * gmag + 64'h8000) >> 16;
		m2n = ({48'd0, beta2} * m2o + (64'd65536 - beta2) * q + 64'h8000) >> 16;
		m2n &= 64'hFFFF_FFFF_FFFF;
		m1_store[w.param_index] = m1n[31:0];
		m2_store[w.param_index] = m2n[47:0];

		d1 = 64'h1_0000_0000 - beta1_pow;
		d2 = 64'h1_0000_0000 - beta2_pow;
		neg = m1n < 0;
		amag = neg ? -m1n : m1n;
		a = amag / d1;
		r = amag % d1;
		if (a >= (64'd1 << 30)) amag = {1'b0, A_MAX};
		else amag = (a << 32) + (r << 32) / d1;
		a = m2n / d2;
		r = m2n % d2;
		if (a >= (64'd1 << 17)) h = 64'(H_MAX);
		else h = (a << 32) + (r << 32) / d2;
		if (h > H_MAX) h = 64'(H_MAX);
		s = root64((h + eps) << 14);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (amag == 0) begin
			mag = 0;
		end else if (s == 0) begin
			mag = lim;
			sat = 1;
		end else begin
			a = amag / s;
			r = amag % s;
			if (a >= (64'd1 << 32)) begin
				mag = lim;
				sat = 1;
			end else begin
				mag = (a << 23) + (r << 23) / s;
				if (mag > lim) begin
					mag = lim;
					sat = 1;
				end
			end
		end
		o.out_index = w.param_index;
		o.adjusted_grad = neg ? -mag[31:0] : mag[31:0];
		o.saturated = sat;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			beta1_pow = POW_ONE;
			beta2_pow = POW_ONE;
			beta1 = DECAY_FIRST_RST;
			beta2 = DECAY_SECOND_RST;
			eps = EPSILON_RST;
			errors = 0;
			direction_q.delete();
			pending = 0;
			for (int i = 0; i < NUM_PARAMS_DEF; i++) begin
				m1_store[i] = '0;
				m2_store[i] = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DECAY_FIRST:  beta1 = cfg_data[BETA_W-1:0];
					REG_DECAY_SECOND: beta2 = cfg_data[BETA_W-1:0];
					REG_EPSILON:      eps = cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (direction_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, actual %h", $time, out_word);
				end else begin
					exp_w = direction_q.pop_front();
					if (out_word.out_index !== exp_w.out_index) begin
						errors++;
						$display("%0t: out_index expected %0d actual %0d", $time,
							exp_w.out_index, out_word.out_index);
					end
					if (out_word.adjusted_grad !== exp_w.adjusted_grad) begin
						errors++;
						$display("%0t: adjusted_grad idx %0d expected %h actual %h", $time,
							exp_w.out_index, exp_w.adjusted_grad, out_word.adjusted_grad);
					end
					if (out_word.saturated !== exp_w.saturated) begin
						errors++;
						$display("%0t: saturated idx %0d expected %b actual %b", $time,
							exp_w.out_index, exp_w.saturated, out_word.saturated);
					end
				end
			end
			if (in_valid && in_ready)
				direction_q.push_back(adam_direction(in_word));
			pending = direction_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_adam_gradient_adjuster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adam_gradient_adjuster
// Drives gradient words through the adjuster under several decay and epsilon
// settings, with random stalls on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_adam_gradient_adjuster;
	import agad_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int RANDOM_ITEMS   = 850;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors, pending;
	int                    tx_idle_pct, rx_idle_pct;
	int                    sent, quiet_cycles;
	bit                    written [NUM_PARAMS_DEF];

	agad_stream_if #(.word_t(in_word_t))  grad_ch ();
	agad_stream_if #(.word_t(out_word_t)) dir_ch ();

	adam_gradient_adjuster i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.grad      (grad_ch.sink),
		.adjusted  (dir_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	adam_direction_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (grad_ch.valid),
		.in_ready  (grad_ch.ready),
		.in_word   (grad_ch.data),
		.out_valid (dir_ch.valid),
		.out_ready (dir_ch.ready),
		.out_word  (dir_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		dir_ch.ready <= $urandom_range(99) >= rx_idle_pct;
	end

	always @(posedge clk) begin
		if ((grad_ch.valid && grad_ch.ready) || (dir_ch.valid && dir_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push(logic [9:0] idx, logic [31:0] g, logic step, logic run);
		in_word_t w;
		w.param_index = idx;
		w.grad_value = g;
		w.step_begin = step;
		w.run_begin = run;
		// idling profile moves on with progress through the random part
		if (sent < RANDOM_ITEMS / 3) begin
			tx_idle_pct = 36;
			rx_idle_pct = 54;
		end else if (sent < 2 * RANDOM_ITEMS / 3) begin
			tx_idle_pct = 54;
			rx_idle_pct = 36;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			grad_ch.valid <= 0;
			@(posedge clk);
		end
		grad_ch.valid <= 1;
		grad_ch.data <= w;
		@(posedge clk);
		while (!grad_ch.ready) @(posedge clk);
		written[idx] = 1;
		sent++;
	endtask

	task automatic wait_drained();
		grad_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] b1, logic [15:0] b2, logic [31:0] e);
		cfg_we <= 1;
		cfg_index <= REG_DECAY_FIRST;
		cfg_data <= {16'd0, b1};
		@(posedge clk);
		cfg_index <= REG_DECAY_SECOND;
		cfg_data <= {16'd0, b2};
		@(posedge clk);
		cfg_index <= REG_EPSILON;
		cfg_data <= e;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] pick_grad();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = $urandom_range(255);
			1: v = $urandom_range(1 << 26);
			2: case ($urandom_range(3))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 32'h0;
				default: v = 32'h1;
			endcase
			default: return $urandom;
		endcase
		return $urandom_range(1) ? -v : v;
	endfunction

	// well-formed runs over small index windows, with some stray words
	task automatic random_words(int n);
		int goal, base, span, nsteps, nwords;
		logic [9:0] idx;
		logic step, run;
		goal = sent + n;
		while (sent < goal) begin
			if ($urandom_range(99) < 85) begin
				base = $urandom_range(1023);
				span = $urandom_range(1, 12);
				nsteps = $urandom_range(1, 4);
				for (int k = 0; k < span; k++)
					push(10'((base + k) % 1024), pick_grad(), k == 0, 1);
				for (int s = 1; s < nsteps; s++) begin
					nwords = $urandom_range(1, 10);
					for (int k = 0; k < nwords; k++)
						push(10'((base + $urandom_range(span - 1)) % 1024), pick_grad(),
							k == 0, 0);
				end
			end else begin
				idx = 10'($urandom);
				step = 1'($urandom);
				run = 1'($urandom);
				if (!written[idx]) run = 1;
				push(idx, pick_grad(), step, run);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_DECAY_FIRST;
		cfg_data = '0;
		grad_ch.valid = 0;
		grad_ch.data = '0;
		dir_ch.ready = 0;
		tx_idle_pct = 36;
		rx_idle_pct = 54;
		sent = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// field extremes, run start, plain step, run start with no step
		push(10'd1023, 32'h7FFF_FFFF, 1, 1);
		push(10'd0, 32'h8000_0000, 0, 1);
		push(10'd1, 32'h0, 0, 1);
		push(10'd2, 32'hFFFF_FFFF, 0, 1);
		push(10'd3, 32'h1, 0, 1);
		push(10'd1023, 32'h8000_0000, 1, 0);
		push(10'd1023, 32'h7FFF_FFFF, 0, 0);
		push(10'd1023, 32'h0100_0000, 0, 0);
		push(10'd0, 32'h7FFF_FFFF, 0, 0);
		push(10'd5, 32'h0000_0100, 0, 1);
		push(10'd5, 32'hFFFF_FF00, 0, 0);
		push(10'd2, 32'h5555_5555, 1, 0);
		push(10'd3, 32'hAAAA_AAAA, 0, 0);
		sent = 0;
		random_words(RANDOM_ITEMS / 6);

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
				0: write_regs(16'd0, 16'd0, 32'd0);
				1: write_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
				2: write_regs(16'd0, 16'hFFFF, 32'd0);
				3: write_regs(16'($urandom), 16'($urandom), $urandom);
				default: write_regs(DECAY_FIRST_RST, DECAY_SECOND_RST, EPSILON_RST);
			endcase
			if (ph == 0) begin
				// zero root: tiny gradient, no epsilon
				push(10'd7, 32'h1, 1, 1);
				push(10'd8, 32'hFFFF_FFFF, 0, 1);
				push(10'd9, 32'h0, 0, 1);
			end
			random_words(RANDOM_ITEMS / 6);
		end

		grad_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
